@@ rtl/core/kv_block_allocator_macros.svh @@
// Assertion macros for the block allocator
`ifndef KV_BLOCK_ALLOCATOR_MACROS_SVH
`define KV_BLOCK_ALLOCATOR_MACROS_SVH

// check a property on every clock edge outside reset
`define KVBA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check an implication whose consequent must hold in the cycle after the antecedent
`define KVBA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/kvba_pkg.sv @@
`timescale 1ns / 1ps
package kvba_pkg;

	localparam logic [2:0] OP_ALLOC = 3'd0;
	localparam logic [2:0] OP_FREE  = 3'd1;
	localparam logic [2:0] OP_SWOUT = 3'd2;
	localparam logic [2:0] OP_SWIN  = 3'd3;
	localparam logic [2:0] OP_READ  = 3'd4;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NO_SPACE   = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND  = 2'd2;
	localparam logic [1:0] ST_OVER_LIMIT = 2'd3;

	localparam int unsigned BS_RESET = 16;

	typedef struct packed {
		logic [2:0]  op;
		logic [5:0]  seq_id;
		logic [15:0] token_count;
	} kvba_in_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] block_id;
		logic       block_valid;
		logic       last;
		logic [8:0] free_count;
		logic [4:0] table_length;
	} kvba_out_t;

	typedef enum logic [3:0] {
		S_INIT,     // fill free stack, clear sequence records
		S_IDLE,
		S_LOAD,     // sequence record arrives from RAM
		S_DIV,      // one quotient bit per cycle
		S_DECIDE,
		S_POP_RD,   // read stack top
		S_POP_WR,   // write id into table
		S_PUSH_RD,  // read table entry
		S_PUSH_WR,  // write id onto stack
		S_EMIT_RD,  // read table entry for output
		S_EMIT_WR,  // present table word
		S_STATUS,   // present status word
		S_WAIT      // wait for output to drain
	} kvba_state_t;

endpackage

@@ rtl/core/kv_block_allocator.sv @@
`timescale 1ns / 1ps
// kv_block_allocator: paged key/value cache block allocator.
// Input channel (in_valid/in_stall, word in_data) carries op, seq_id and
// token_count. Output channel (out_valid/out_stall, word out_data) returns
// one status word, or one word per table entry with last on the final one.
// Config channel (cfg_valid/cfg_ready, cfg_data) sets block_size_tokens;
// it is always ready, and the user must write it only while the block is
// idle; the block itself does not enforce this. One item at a time:
// in_stall is high from acceptance until its last word has left the output
// register. Every item first fetches its sequence record; allocate then
// runs the serial divider and a decide step, then a read and a write step
// per popped block and per emitted entry. Free and swap out take a read and
// a write step per block pushed back, swap in per block popped.
// After reset the free stack is filled with ids 0..NUM_BLOCKS-1 and the
// sequence records are cleared, one entry of each per cycle, with in_stall
// high meanwhile.
// A stalled output word holds; the sequencer waits before the next word.
`include "kv_block_allocator_macros.svh"
module kv_block_allocator
	import kvba_pkg::*;
#(
	parameter int NUM_BLOCKS         = 256,
	parameter int NUM_SEQS           = 64,
	parameter int MAX_BLOCKS_PER_SEQ = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  kvba_in_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output kvba_out_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [12:0] cfg_data
);

	localparam int BW  = $clog2(NUM_BLOCKS);
	localparam int CW  = $clog2(NUM_BLOCKS + 1);
	localparam int SW  = (NUM_SEQS > 1) ? $clog2(NUM_SEQS) : 1;
	localparam int LW  = $clog2(MAX_BLOCKS_PER_SEQ + 1);
	localparam int TD  = NUM_SEQS * MAX_BLOCKS_PER_SEQ;
	localparam int TW  = (TD > 1) ? $clog2(TD) : 1;
	localparam int INIT_N = (NUM_BLOCKS > NUM_SEQS) ? NUM_BLOCKS : NUM_SEQS;
	localparam int IW  = $clog2(INIT_N + 1);

	kvba_state_t state_q, state_d;

	logic [12:0]   bs_q;
	logic [CW-1:0] top_q;
	logic [LW-1:0] len_q;    // resident length of the current sequence
	logic [LW-1:0] swp_q;    // swapped count of the current sequence

	// current item
	logic [2:0]    op_q;
	logic [SW-1:0] seq_q;
	logic          seq_ok_q;
	logic [16:0]   rem_q;    // divider partial remainder
	logic [15:0]   quo_q;    // dividend shifting to quotient
	logic [4:0]    dcnt_q;
	logic [LW-1:0] idx_q;    // walk index
	logic [LW-1:0] cnt_q;    // target length for pops / count to push
	logic [LW-1:0] n_old_q;  // resident length at start (swap out)
	logic [IW-1:0] init_q;
	logic [1:0]    st_q;

	// output register
	logic      ov_q;
	kvba_out_t od_q;

	// RAM ports
	logic          fs_we;
	logic [BW-1:0] fs_wa, fs_ra, fs_wd, fs_rd;
	logic          tb_we;
	logic [TW-1:0] tb_wa, tb_ra;
	logic [7:0]    tb_rd;
	logic [BW-1:0] tb_wd;
	logic [BW-1:0] tb_rd_full;
	logic            si_we;
	logic [SW-1:0]   si_wa, si_ra;
	logic [2*LW-1:0] si_wd, si_rd;

	kvba_ram #(.WIDTH(BW), .DEPTH(NUM_BLOCKS)) u_free_stack (
		.clk(clk), .we(fs_we), .waddr(fs_wa), .wdata(fs_wd),
		.raddr(fs_ra), .rdata(fs_rd)
	);
	kvba_ram #(.WIDTH(BW), .DEPTH(TD)) u_table (
		.clk(clk), .we(tb_we), .waddr(tb_wa), .wdata(tb_wd),
		.raddr(tb_ra), .rdata(tb_rd_full)
	);
	// per-sequence record: swapped count above resident length
	kvba_ram #(.WIDTH(2 * LW), .DEPTH(NUM_SEQS)) u_seq_info (
		.clk(clk), .we(si_we), .waddr(si_wa), .wdata(si_wd),
		.raddr(si_ra), .rdata(si_rd)
	);
	assign tb_rd = 8'(tb_rd_full);
	assign si_ra = SW'(in_data.seq_id);

	logic [LW-1:0] len_cur, swp_cur;
	assign len_cur = seq_ok_q ? len_q : '0;
	assign swp_cur = seq_ok_q ? swp_q : '0;

	logic [12:0] bs_eff;
	assign bs_eff = (bs_q == 13'd0) ? 13'd1 : bs_q;

	// ceiling division: quotient plus one if remainder nonzero
	logic [16:0] need_w;
	assign need_w = 17'(quo_q) + 17'(rem_q != 17'd0);

	logic [16:0] trial;
	assign trial = {rem_q[15:0], quo_q[15]} - 17'(bs_eff);

	logic [TW-1:0] tb_base;
	assign tb_base = TW'(seq_q) * TW'(MAX_BLOCKS_PER_SEQ);

	logic out_free;
	assign out_free = !ov_q || !out_stall;

	// output register takes a new word
	logic ov_load;
	assign ov_load = (state_q == S_EMIT_WR) || (state_q == S_STATUS && out_free);

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = ov_q;
	assign out_data  = od_q;

	// next state and RAM controls
	always_comb begin
		state_d = state_q;
		fs_we = 1'b0;
		fs_wa = BW'(init_q);
		fs_wd = BW'(init_q);
		fs_ra = BW'(top_q - CW'(1));
		tb_we = 1'b0;
		tb_wa = tb_base + TW'(len_cur);
		tb_wd = fs_rd;
		tb_ra = tb_base + TW'(idx_q);
		si_we = 1'b0;
		si_wa = seq_q;
		si_wd = {swp_q, len_q};
		unique case (state_q)
			S_INIT: begin
				fs_we = (32'(init_q) < NUM_BLOCKS);
				si_we = (32'(init_q) < NUM_SEQS);
				si_wa = SW'(init_q);
				si_wd = '0;
				if (init_q == IW'(INIT_N - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_d = S_LOAD;
			end
			S_LOAD: begin
				if (op_q > OP_READ || !seq_ok_q) state_d = S_STATUS;
				else if (op_q == OP_ALLOC) state_d = S_DIV;
				else state_d = S_DECIDE;
			end
			S_DIV: begin
				if (dcnt_q == 5'd15) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				unique case (op_q)
					OP_ALLOC: begin
						if (need_w <= 17'(len_cur)) state_d = S_EMIT_RD;
						else if (need_w > 17'(MAX_BLOCKS_PER_SEQ)) state_d = S_STATUS;
						else if (need_w - 17'(len_cur) > 17'(top_q)) state_d = S_STATUS;
						else state_d = S_POP_RD;
					end
					OP_FREE, OP_SWOUT: begin
						if (len_cur == '0) state_d = S_STATUS;
						else state_d = S_PUSH_RD;
					end
					OP_SWIN: begin
						if (swp_cur == '0) state_d = S_STATUS;
						else if (32'(len_cur) + 32'(swp_cur) > MAX_BLOCKS_PER_SEQ)
							state_d = S_STATUS;
						else if (CW'(swp_cur) > top_q) state_d = S_STATUS;
						else state_d = S_POP_RD;
					end
					default: state_d = S_EMIT_RD;
				endcase
			end
			S_POP_RD: state_d = S_POP_WR;
			S_POP_WR: begin
				tb_we = 1'b1;
				if (len_cur + LW'(1) == cnt_q)
					state_d = (op_q == OP_ALLOC) ? S_EMIT_RD : S_STATUS;
				else state_d = S_POP_RD;
			end
			S_PUSH_RD: state_d = S_PUSH_WR;
			S_PUSH_WR: begin
				fs_we = 1'b1;
				fs_wa = BW'(top_q);
				fs_wd = BW'(tb_rd_full);
				if (idx_q + LW'(1) == cnt_q) state_d = S_STATUS;
				else state_d = S_PUSH_RD;
			end
			S_EMIT_RD: begin
				if (len_cur == '0) state_d = S_STATUS;
				else if (out_free) state_d = S_EMIT_WR;
			end
			S_EMIT_WR: begin
				if (idx_q + LW'(1) == len_cur) state_d = S_WAIT;
				else state_d = S_EMIT_RD;
			end
			S_STATUS: begin
				if (out_free) state_d = S_WAIT;
			end
			S_WAIT: begin
				// record goes back once the item is complete
				si_we = seq_ok_q;
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_INIT;
		else state_q <= state_d;
	end

	// datapath and bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q   <= 13'(BS_RESET);
			top_q  <= CW'(NUM_BLOCKS);
			init_q <= '0;
			ov_q   <= 1'b0;
			len_q  <= '0;
			swp_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) bs_q <= cfg_data;
			if (ov_load) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
			unique case (state_q)
				S_INIT: init_q <= init_q + IW'(1);
				S_IDLE: begin
					if (in_valid) begin
						op_q     <= in_data.op;
						seq_q    <= SW'(in_data.seq_id);
						seq_ok_q <= 32'(in_data.seq_id) < NUM_SEQS;
						rem_q    <= '0;
						quo_q    <= in_data.token_count;
						dcnt_q   <= '0;
						idx_q    <= '0;
						st_q     <= (in_data.op > OP_READ) ? ST_OK :
							(!(32'(in_data.seq_id) < NUM_SEQS)) ? ST_NOT_FOUND : ST_OK;
					end
				end
				S_LOAD: begin
					len_q <= si_rd[LW-1:0];
					swp_q <= si_rd[2*LW-1:LW];
				end
				S_DIV: begin
					// restoring divide, one bit per cycle
					if (!trial[16]) begin
						rem_q <= trial;
						quo_q <= {quo_q[14:0], 1'b1};
					end else begin
						rem_q <= {rem_q[15:0], quo_q[15]};
						quo_q <= {quo_q[14:0], 1'b0};
					end
					dcnt_q <= dcnt_q + 5'd1;
				end
				S_DECIDE: begin
					n_old_q <= len_cur;
					unique case (op_q)
						OP_ALLOC: begin
							cnt_q <= LW'(need_w);
							if (need_w > 17'(len_cur)) begin
								if (need_w > 17'(MAX_BLOCKS_PER_SEQ)) st_q <= ST_OVER_LIMIT;
								else if (need_w - 17'(len_cur) > 17'(top_q))
									st_q <= ST_NO_SPACE;
							end
						end
						OP_FREE: begin
							cnt_q <= len_cur;
							swp_q <= '0;
						end
						OP_SWOUT: begin
							cnt_q <= len_cur;
							if (len_cur == '0) st_q <= ST_NOT_FOUND;
						end
						OP_SWIN: begin
							cnt_q <= len_cur + swp_cur;
							if (swp_cur == '0) st_q <= ST_NOT_FOUND;
							else if (32'(len_cur) + 32'(swp_cur) > MAX_BLOCKS_PER_SEQ)
								st_q <= ST_OVER_LIMIT;
							else if (CW'(swp_cur) > top_q) st_q <= ST_NO_SPACE;
							else swp_q <= '0;
						end
						default: ;
					endcase
				end
				S_POP_WR: begin
					top_q <= top_q - CW'(1);
					len_q <= len_cur + LW'(1);
				end
				S_PUSH_WR: begin
					top_q <= top_q + CW'(1);
					idx_q <= idx_q + LW'(1);
					if (idx_q + LW'(1) == cnt_q) begin
						len_q <= '0;
						if (op_q == OP_SWOUT) swp_q <= n_old_q;
					end
				end
				S_EMIT_WR: begin
					od_q.status       <= ST_OK;
					od_q.block_id     <= tb_rd;
					od_q.block_valid  <= 1'b1;
					od_q.last         <= (idx_q + LW'(1) == len_cur);
					od_q.free_count   <= 9'(top_q);
					od_q.table_length <= 5'(len_cur);
					idx_q <= idx_q + LW'(1);
				end
				S_STATUS: begin
					if (out_free) begin
						od_q.status       <= st_q;
						od_q.block_id     <= '0;
						od_q.block_valid  <= 1'b0;
						od_q.last         <= 1'b1;
						od_q.free_count   <= 9'(top_q);
						od_q.table_length <= 5'(len_cur);
					end
				end
				default: ;
			endcase
		end
	end

	// assertions
	`KVBA_ASSERT(a_top_range, top_q <= CW'(NUM_BLOCKS), "free count out of range")
	`KVBA_ASSERT(a_busy_no_accept, !(in_stall == 1'b0 && ov_q && state_q != S_IDLE),
		"input open while busy")
	`KVBA_ASSERT_NEXT(a_emit_valid, state_q == S_EMIT_WR, ov_q, "table word not presented")

endmodule

@@ rtl/core/kvba_ram.sv @@
`timescale 1ns / 1ps
module kvba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
